@@ src/atrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrp_pkg
// Types and constants shared by the tilt (roll/pitch) block.
// ----------------------------------------------------------------------------
package atrp_pkg;

  // Arctangent table: atan(2^-i) in degrees * 65536, rounded to nearest.
  localparam int AtanLen = 24;

  function automatic logic [23:0] atan_q16(input logic [4:0] i);
    logic [23:0] v;
    begin
      case (i)
        5'd0:  v = 24'd2949120;
        5'd1:  v = 24'd1740967;
        5'd2:  v = 24'd919879;
        5'd3:  v = 24'd466945;
        5'd4:  v = 24'd234379;
        5'd5:  v = 24'd117304;
        5'd6:  v = 24'd58666;
        5'd7:  v = 24'd29335;
        5'd8:  v = 24'd14668;
        5'd9:  v = 24'd7334;
        5'd10: v = 24'd3667;
        5'd11: v = 24'd1833;
        5'd12: v = 24'd917;
        5'd13: v = 24'd458;
        5'd14: v = 24'd229;
        5'd15: v = 24'd115;
        5'd16: v = 24'd57;
        5'd17: v = 24'd29;
        5'd18: v = 24'd14;
        5'd19: v = 24'd7;
        5'd20: v = 24'd4;
        5'd21: v = 24'd2;
        5'd22: v = 24'd1;
        default: v = 24'd0;
      endcase
      return v;
    end
  endfunction

  // 180 degrees in the accumulator scale.
  localparam logic signed [31:0] Deg180Q16 = 32'sd11796480;

  // Clamp limits in 1/16 degree.
  localparam logic signed [31:0] RollLim  = 32'sd2880;
  localparam logic signed [31:0] PitchLim = 32'sd1440;

  // CORDIC command from the sequencer.
  typedef struct packed {
    logic start;
    logic is_pitch;
  } cordic_cmd_t;

endpackage
`default_nettype wire

@@ src/atrp_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atrp_cordic
// Iterative CORDIC vectoring unit: atan2(y, x) in 1/16 degree, one
// micro-rotation per cycle, clamped to the limit the command selects.
// ----------------------------------------------------------------------------
module atrp_cordic
  import atrp_pkg::*;
#(
  parameter int W     = 32,
  parameter int ITERS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cordic_cmd_t         cmd,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  output logic                     done,
  output logic signed [12:0]       angle
);

  localparam int IW = $clog2(ITERS + 1);

  logic signed [W:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0]  z_r, z_nxt;
  logic [IW-1:0]       it_r, it_nxt;
  logic                busy_r, busy_nxt, zero_r, zero_nxt, pit_r, pit_nxt;
  logic                done_r, done_nxt;
  logic signed [12:0]  ang_r, ang_nxt;
  logic signed [W:0]   xs, ys;
  logic signed [31:0]  ta, rnd, lim;
  logic [4:0]          tidx;

  always_comb begin
    tidx = (it_r < IW'(AtanLen)) ? 5'(it_r) : 5'd31;
    ta   = $signed({8'd0, atan_q16(tidx)});
    xs   = x_r >>> it_r;
    ys   = y_r >>> it_r;
    rnd  = (z_r + 32'sd2048) >>> 12;
    lim  = pit_r ? PitchLim : RollLim;
  end

  // Sequencer and shared add/subtract datapath.
  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; it_nxt = it_r;
    busy_nxt = busy_r; zero_nxt = zero_r; pit_nxt = pit_r;
    done_nxt = 1'b0; ang_nxt = ang_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      pit_nxt  = cmd.is_pitch;
      zero_nxt = (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        z_nxt = (y_in >= 0) ? Deg180Q16 : -Deg180Q16;
        x_nxt = -{x_in[W-1], x_in};
        y_nxt = -{y_in[W-1], y_in};
      end else begin
        z_nxt = '0;
        x_nxt = {x_in[W-1], x_in};
        y_nxt = {y_in[W-1], y_in};
      end
    end else if (busy_r) begin
      if (it_r == IW'(ITERS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (zero_r)          ang_nxt = '0;
        else if (rnd > lim)  ang_nxt = 13'(lim);
        else if (rnd < -lim) ang_nxt = 13'(-lim);
        else                 ang_nxt = 13'(rnd);
      end else begin
        it_nxt = it_r + 1'b1;
        if (y_r >= 0) begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + ta;
        end else begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - ta;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt;
    zero_r <= zero_nxt; pit_r <= pit_nxt; ang_r <= ang_nxt;
  end

  assign done  = done_r;
  assign angle = ang_r;

  // A result appears only at the end of a pass.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without pass");
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (ang_r <= 13'sd2880 && ang_r >= -13'sd2880))
    else $error("angle out of range");

endmodule
`default_nettype wire

@@ src/accel_tilt_roll_pitch_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_top
// Low-pass filters an accelerometer triple and returns roll and pitch.
//
//  channel | ports                                  | direction
//  in      | in_valid/ready, in_x/y/z_sample        | sink
//  out     | out_valid/ready, out_roll/pitch_angle  | source
//  cfg     | cfg_valid/ready, cfg_alpha_q8          | sink
//
// out_valid rises after a word is accepted and has passed three filter steps,
// two squaring steps, the roll CORDIC pass, a square root of RW bits
// (RW = SAMPLE_BITS+FRAC_BITS+1) and the pitch CORDIC pass. in_ready is low
// while a word is in work or a result waits. Reset clears the filter state
// and sets alpha to 128.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch_top
  import atrp_pkg::*;
#(
  parameter int SAMPLE_BITS  = 12,
  parameter int FRAC_BITS    = 8,
  parameter int CORDIC_ITERS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_x_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_y_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_z_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [12:0]                 out_roll_angle,
  output logic [11:0]                 out_pitch_angle,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [8:0]             cfg_alpha_q8
);

  localparam int FW  = SAMPLE_BITS + FRAC_BITS;   // filter state width
  localparam int SW  = 2 * FW + 2;                // sum of squares width
  localparam int RW  = FW + 1;                    // root width
  localparam int RIW = $clog2(RW + 1);
  localparam int CW  = FW + 2;                    // cordic operand width

  localparam logic [2:0] S_IDLE = 3'd0, S_FILT = 3'd1, S_SQ = 3'd2,
                         S_ROLL = 3'd3, S_SQRT = 3'd4, S_PITCH = 3'd5,
                         S_OUT = 3'd6;

  logic [2:0]            st_r, st_nxt;
  logic [8:0]            alpha_r;
  logic signed [FW-1:0]  fx_r, fy_r, fz_r, fx_nxt, fy_nxt, fz_nxt;
  logic signed [SAMPLE_BITS-1:0] sx_r, sy_r, sz_r;
  logic [1:0]            ax_r, ax_nxt;
  logic [SW-1:0]         rem_r, rem_nxt, sq_r, sq_nxt;
  logic [RW-1:0]         root_r, root_nxt;
  logic [RIW-1:0]        ri_r, ri_nxt;
  logic                  cstart_r, cstart_nxt;
  logic signed [12:0]    roll_r, roll_nxt;
  logic [11:0]           pitch_r, pitch_nxt;
  logic                  ov_r, ov_nxt;
  cordic_cmd_t           cmd;
  logic signed [CW-1:0]  cx, cy;
  logic                  cdone;
  logic signed [12:0]    cang;

  // Filter step on one axis (shared multiplier pair).
  logic signed [SAMPLE_BITS-1:0] s_sel;
  logic signed [FW-1:0]  f_sel, f_new;
  logic signed [9:0]     a_w;
  logic signed [FW+10:0] acc;
  always_comb begin
    a_w   = (alpha_r > 9'd256) ? 10'sd256 : $signed({1'b0, alpha_r});
    s_sel = (ax_r == 2'd0) ? sx_r : (ax_r == 2'd1) ? sy_r : sz_r;
    f_sel = (ax_r == 2'd0) ? fx_r : (ax_r == 2'd1) ? fy_r : fz_r;
    acc   = a_w * $signed({s_sel, {FRAC_BITS{1'b0}}})
          + (10'sd256 - a_w) * f_sel;
    f_new = FW'(acc >>> 8);
  end

  // Square of the selected filtered axis.
  logic signed [FW-1:0]  sq_in;
  logic signed [2*FW-1:0] sq_prod;
  logic [SW-1:0]         sq_val, trial;
  always_comb begin
    sq_in   = (ax_r == 2'd0) ? fy_r : fz_r;
    sq_prod = sq_in * sq_in;
    sq_val  = SW'($unsigned(sq_prod));
  end

  // Bit-pair of the restoring square root.
  logic [SW-1:0]         bitv;
  always_comb begin
    bitv  = SW'(1) << (2 * (RW - 1 - ri_r));
    trial = SW'(root_r) << (RW - ri_r);
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; fx_nxt = fx_r; fy_nxt = fy_r; fz_nxt = fz_r;
    ax_nxt = ax_r; rem_nxt = rem_r; sq_nxt = sq_r; root_nxt = root_r;
    ri_nxt = ri_r; cstart_nxt = 1'b0; roll_nxt = roll_r;
    pitch_nxt = pitch_r; ov_nxt = ov_r;
    cmd.start = cstart_r;
    cmd.is_pitch = (st_r == S_PITCH);
    cx = (st_r == S_PITCH) ? CW'($signed({1'b0, root_r})) : CW'(fz_r);
    cy = (st_r == S_PITCH) ? CW'(fx_r) : -CW'(fy_r);
    case (st_r)
      S_IDLE: if (in_valid) begin
        st_nxt = S_FILT; ax_nxt = 2'd0;
      end
      S_FILT: begin
        if (ax_r == 2'd0) fx_nxt = f_new;
        if (ax_r == 2'd1) fy_nxt = f_new;
        if (ax_r == 2'd2) begin
          fz_nxt = f_new; ax_nxt = 2'd0; st_nxt = S_SQ; sq_nxt = '0;
        end else ax_nxt = ax_r + 2'd1;
      end
      S_SQ: begin
        sq_nxt = sq_r + sq_val;
        if (ax_r == 2'd1) begin
          st_nxt = S_ROLL; cstart_nxt = 1'b1;
          rem_nxt = sq_r + sq_val; root_nxt = '0; ri_nxt = '0;
        end else ax_nxt = 2'd1;
      end
      S_ROLL: if (cdone) begin
        roll_nxt = cang; st_nxt = S_SQRT;
      end
      S_SQRT: begin
        // Root kept unshifted; trial = (root << (k+1)) + bit, k bit position.
        if (ri_r == RIW'(RW)) begin
          st_nxt = S_PITCH; cstart_nxt = 1'b1;
        end else begin
          ri_nxt = ri_r + 1'b1;
          if (rem_r >= trial + bitv) begin
            rem_nxt  = rem_r - (trial + bitv);
            root_nxt = root_r | (RW'(1) << (RW - 1 - ri_r));
          end
        end
      end
      S_PITCH: if (cdone) begin
        pitch_nxt = 12'(cang); st_nxt = S_OUT; ov_nxt = 1'b1;
      end
      S_OUT: if (out_ready) begin
        ov_nxt = 1'b0; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; alpha_r <= 9'd128; ov_r <= 1'b0; cstart_r <= 1'b0;
      fx_r <= '0; fy_r <= '0; fz_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; cstart_r <= cstart_nxt;
      fx_r <= fx_nxt; fy_r <= fy_nxt; fz_r <= fz_nxt;
      if (cfg_valid) alpha_r <= cfg_alpha_q8;
    end
    if (in_valid && in_ready) begin
      sx_r <= in_x_sample; sy_r <= in_y_sample; sz_r <= in_z_sample;
    end
    ax_r <= ax_nxt; rem_r <= rem_nxt; sq_r <= sq_nxt; root_r <= root_nxt;
    ri_r <= ri_nxt; roll_r <= roll_nxt; pitch_r <= pitch_nxt;
  end

  atrp_cordic #(.W(CW), .ITERS(CORDIC_ITERS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .x_in(cx), .y_in(cy),
    .done(cdone), .angle(cang)
  );

  assign in_ready        = (st_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;

  a_ov_state: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> st_r == S_OUT) else $error("result outside output state");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> st_r == S_FILT) else $error("bad start");
  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ($signed(pitch_r) <= 12'sd1440 && $signed(pitch_r) >= -12'sd1440))
    else $error("pitch out of range");

endmodule
`default_nettype wire

@@ sim/tilt_checker.sv @@
// ----------------------------------------------------------------------------
// tilt_checker
// Watches the sample, result and alpha channels of the tilt block, predicts
// roll and pitch for every accepted sample word and compares each result
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module tilt_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [11:0] in_x_sample,
  input  wire logic [11:0] in_y_sample,
  input  wire logic [11:0] in_z_sample,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [12:0] out_roll_angle,
  input  wire logic [11:0] out_pitch_angle,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [8:0]  cfg_alpha_q8,
  output int               fail_count,
  output int               pending_count,
  output int               words_checked
);

  localparam int SampleFrac = 8;
  localparam int TurnSteps  = 16;
  localparam longint HalfTurn = 64'sd11796480;

  typedef struct packed {
    logic [12:0] roll;
    logic [11:0] pitch;
  } tilt_t;

  tilt_t        tilt_q[$];
  logic [8:0]   alpha_w;
  longint       lp_x, lp_y, lp_z;

  // Arctangent steps in degrees * 65536.
  function automatic longint arc_step(input int i);
    longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                        58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                        229, 115};
    return tab[i];
  endfunction

  // Vectoring arctangent in 1/16 degree, clamped to +-lim.
  function automatic longint vector_angle(input longint yy, input longint xx,
                                          input longint lim);
    longint acc, xn, yn, r;
    acc = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      acc = (yy >= 0) ? HalfTurn : -HalfTurn;
      xx = -xx;
      yy = -yy;
    end
    for (int i = 0; i < TurnSteps; i++) begin
      if (yy >= 0) begin
        xn = xx + (yy >>> i);
        yn = yy - (xx >>> i);
        acc += arc_step(i);
      end else begin
        xn = xx - (yy >>> i);
        yn = yy + (xx >>> i);
        acc -= arc_step(i);
      end
      xx = xn;
      yy = yn;
    end
    r = (acc + 2048) >>> 12;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // Integer floor square root.
  function automatic longint floor_root(input longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint smooth(input longint f, input logic signed [11:0] s,
                                    input longint a);
    longint sc;
    sc = longint'(s) * (64'sd1 << SampleFrac);
    return (a * sc + (256 - a) * f) >>> 8;
  endfunction

  // Update the filter and predict the angles for one sample word.
  function automatic tilt_t predict_tilt(input logic [11:0] sx, input logic [11:0] sy,
                                         input logic [11:0] sz);
    longint a, m;
    tilt_t t;
    a = (alpha_w > 9'd256) ? 256 : longint'(alpha_w);
    lp_x = smooth(lp_x, sx, a);
    lp_y = smooth(lp_y, sy, a);
    lp_z = smooth(lp_z, sz, a);
    m = floor_root(lp_y * lp_y + lp_z * lp_z);
    t.roll  = 13'(vector_angle(-lp_y, lp_z, 2880));
    t.pitch = 12'(vector_angle(lp_x, m, 1440));
    return t;
  endfunction

  assign pending_count = tilt_q.size();

  // Follow the channels at each rising edge.
  always @(posedge clk) begin
    tilt_t exp_t;
    if (!rst_n) begin
      alpha_w <= 9'd128;
      lp_x = 0;
      lp_y = 0;
      lp_z = 0;
      fail_count <= 0;
      words_checked <= 0;
      tilt_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) alpha_w <= cfg_alpha_q8;
      if (in_valid && in_ready)
        tilt_q.push_back(predict_tilt(in_x_sample, in_y_sample, in_z_sample));
      if (out_valid && out_ready) begin
        words_checked <= words_checked + 1;
        if (tilt_q.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_t = tilt_q.pop_front();
          if (exp_t.roll !== out_roll_angle || exp_t.pitch !== out_pitch_angle) begin
            fail_count <= fail_count + 1;
            if (exp_t.roll !== out_roll_angle)
              $error("roll_angle expected %0d actual %0d",
                     $signed(exp_t.roll), $signed(out_roll_angle));
            if (exp_t.pitch !== out_pitch_angle)
              $error("pitch_angle expected %0d actual %0d",
                     $signed(exp_t.pitch), $signed(out_pitch_angle));
          end
        end
      end
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives sample words and alpha settings into the tilt block in bursts with
// random gaps and a stalling receiver; the checker gives the verdict count.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_x_sample = '0, in_y_sample = '0, in_z_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] out_roll_angle;
  logic [11:0] out_pitch_angle;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_alpha_q8 = 9'd128;
  int          fail_count, pending_count, words_checked;
  int          cycle_count = 0;
  int          words_sent = 0;
  int          alpha_sets = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  accel_tilt_roll_pitch_top i_dut (.*);

  tilt_checker i_check (.*);

  // Receiver stalls in a pattern of its own, with calm stretches.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count[12:10] == 3'd5) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Timeout for a run of about 1000 words.
  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("accel_tilt_roll_pitch_top: mismatch");
      $finish;
    end
  end

  // Send one sample word and wait for its acceptance; valid stays high so
  // that a following word can go straight out.
  task automatic send_word(input logic [11:0] sx, input logic [11:0] sy,
                           input logic [11:0] sz);
    in_valid <= 1'b1;
    in_x_sample <= sx;
    in_y_sample <= sy;
    in_z_sample <= sz;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Drain all results, then let the block settle before writing alpha.
  task automatic set_alpha(input logic [8:0] a);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_alpha_q8 <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_sets++;
  endtask

  task automatic random_burst(input int n);
    logic [11:0] bx, by, bz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        bx = 12'($urandom);
        by = 12'($urandom);
        bz = 12'($urandom);
      end else begin
        // Mostly modest tilts around a gravity vector.
        bx = 12'($urandom_range(0, 800) - 400);
        by = 12'($urandom_range(0, 800) - 400);
        bz = 12'($urandom_range(0, 2047) - 1024);
      end
      send_word(bx, by, bz);
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [8:0] alphas[6] = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd200, 9'd257};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed words: zero vector and extremes at the reset alpha, then axis cases.
    send_word(12'h000, 12'h000, 12'h000);
    send_word(12'h7FF, 12'h7FF, 12'h7FF);
    send_word(12'h800, 12'h800, 12'h800);
    set_alpha(9'd256);
    send_word(12'h000, 12'h000, 12'h000);
    send_word(12'h000, 12'h000, 12'h800);
    send_word(12'h000, 12'h000, 12'h7FF);
    send_word(12'h7FF, 12'h000, 12'h000);
    send_word(12'h800, 12'h000, 12'h000);
    send_word(12'h000, 12'h7FF, 12'h000);
    send_word(12'h000, 12'h800, 12'h000);
    send_word(12'h555, 12'hAAA, 12'h800);
    send_word(12'hAAA, 12'h555, 12'h7FF);
    send_word(12'h800, 12'h7FF, 12'h800);
    send_word(12'hFFF, 12'h001, 12'hFFF);
    set_alpha(9'd0);
    send_word(12'h7FF, 12'h800, 12'h123);
    set_alpha(9'd511);
    send_word(12'h123, 12'h800, 12'hFFF);
    // Random phases through several alpha settings.
    foreach (alphas[k]) begin
      set_alpha(alphas[k]);
      random_burst(80);
    end
    for (int k = 0; k < 10; k++) begin
      set_alpha(9'($urandom));
      random_burst(50);
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d sample words, checked %0d results over %0d alpha settings.",
             words_sent, words_checked, alpha_sets);
    if (fail_count == 0 && pending_count == 0)
      $display("accel_tilt_roll_pitch_top: match");
    else
      $display("accel_tilt_roll_pitch_top: mismatch");
    $finish;
  end

endmodule
